// ===== rtl/lad_pkg.sv =====
// Package for the linear array deque: item types, operation and status codes.
`default_nettype none
package lad_pkg;

  localparam int unsigned LadDepth = 8;
  localparam int unsigned DataW    = 32;

  localparam logic [2:0] FUNC_PUSH_REAR  = 3'd0;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd1;
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd2;
  localparam logic [2:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [2:0] FUNC_READ_ALL   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]              func;
    logic signed [DataW-1:0] value_in;
  } lad_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] value_out;
    logic [1:0]              status;
    logic                    last;
  } lad_out_t;

  // controller -> datapath
  typedef struct packed {
    logic cmd_load;
    logic ptr_init;
    logic ptr_inc;
    logic exec_now;
    logic emit_read;
  } lad_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic no_result;
    logic needs_read;
    logic more;
    logic slot_free;
  } lad_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lad_ctrl.sv =====
// Controller state machine for the linear array deque.
`default_nettype none
module lad_ctrl
  import lad_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lad_stat_t stat_i,
  output lad_ctrl_t      ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd_load = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.no_result) begin
          state_d = S_IDLE;
        end else if (stat_i.needs_read) begin
          ctrl_o.ptr_init = 1'b1;
          state_d         = S_READ;
        end else if (stat_i.slot_free) begin
          ctrl_o.exec_now = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.slot_free) begin
          ctrl_o.emit_read = 1'b1;
          if (stat_i.more) begin
            ctrl_o.ptr_inc = 1'b1;
            state_d        = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lad_dpath.sv =====
// Datapath for the linear array deque: indices, element memory, result register.
`default_nettype none
module lad_dpath
  import lad_pkg::*;
#(
  parameter int unsigned DEPTH = LadDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lad_in_t   in_item_i,
  input  wire lad_ctrl_t ctrl_i,
  output lad_stat_t      stat_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lad_out_t       out_item_o
);

  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [IW-1:0] DepthIw = IW'(DEPTH);

  // indices are held one above the model's: f = front + 1, r = rear + 1
  logic [IW-1:0] f_q, f_d, r_q, r_d;
  logic [IW-1:0] f_m1, r_m1;
  logic [AW-1:0] ptr_q, ptr_d;
  lad_in_t       cmd_q;
  lad_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic signed [DataW-1:0] mem_q [DEPTH];
  logic signed [DataW-1:0] rd_data_q;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  logic empty, is_pop, last_elem;

  assign f_m1      = f_q - 1'b1;
  assign r_m1      = r_q - 1'b1;
  assign empty     = (f_q == r_q);
  assign is_pop    = (cmd_q.func == FUNC_POP_FRONT) || (cmd_q.func == FUNC_POP_REAR) ||
                     (cmd_q.func == FUNC_READ_ALL);
  assign last_elem = (ptr_q == r_m1[AW-1:0]);

  assign stat_o.no_result  = (cmd_q.func > FUNC_READ_ALL);
  assign stat_o.needs_read = is_pop && !empty;
  assign stat_o.more       = (cmd_q.func == FUNC_READ_ALL) && !last_elem;
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    f_d         = f_q;
    r_d         = r_q;
    ptr_d       = ptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_addr     = r_q[AW-1:0];

    if (ctrl_i.ptr_init) begin
      ptr_d = (cmd_q.func == FUNC_POP_REAR) ? r_m1[AW-1:0] : f_q[AW-1:0];
    end
    if (ctrl_i.ptr_inc) begin
      ptr_d = ptr_q + 1'b1;
    end

    if (ctrl_i.exec_now) begin
      out_valid_d     = 1'b1;
      out_d.value_out = '0;
      out_d.last      = 1'b1;
      case (cmd_q.func)
        FUNC_PUSH_REAR: begin
          if (r_q == DepthIw) begin
            out_d.status = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = r_q[AW-1:0];
            r_d          = r_q + 1'b1;
            out_d.status = ST_OK;
          end
        end
        FUNC_PUSH_FRONT: begin
          if (f_q == '0) begin
            out_d.status = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = f_m1[AW-1:0];
            f_d          = f_m1;
            out_d.status = ST_OK;
          end
        end
        default: out_d.status = ST_EMPTY;
      endcase
    end

    if (ctrl_i.emit_read) begin
      out_valid_d     = 1'b1;
      out_d.value_out = rd_data_q;
      out_d.status    = ST_OK;
      out_d.last      = (cmd_q.func != FUNC_READ_ALL) || last_elem;
      case (cmd_q.func)
        FUNC_POP_FRONT: f_d = f_q + 1'b1;
        FUNC_POP_REAR:  r_d = r_m1;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q         <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      f_q         <= f_d;
      r_q         <= r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd_load) begin
      cmd_q <= in_item_i;
    end
    ptr_q <= ptr_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_q.value_in;
    end
    rd_data_q <= mem_q[ptr_q];
  end

endmodule
`default_nettype wire

// ===== rtl/linear_array_deque_top.sv =====
// Linear array deque: one input channel of operations, one output channel of results.
//   in_item_i carries func (push rear, pop front, push front, pop rear, read all)
//   and value_in; out_item_o carries value_out, status and last.
//   One item is in flight at a time; in_ready_o is high while the controller idles.
//   Push or refused/empty op: S_EXEC loads the result once the output slot is free.
//   Pop: execute, memory read, registered read data, emit.
//   Read all of n elements: one element per memory read and emit.
//   Unused func codes give no result.
//   The element memory has a single registered read port.
//   Results sit in an output register; when the receiver stalls, the block
//   holds the result and waits before issuing the next one.
//   Reset sets both indices to minus one (empty queue) and drops any pending
//   result; the element memory is not cleared.
`default_nettype none
module linear_array_deque_top
  import lad_pkg::*;
#(
  parameter int unsigned DEPTH = LadDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire lad_in_t in_item_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output lad_out_t     out_item_o
);

  lad_ctrl_t ctrl;
  lad_stat_t stat;

  lad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lad_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== test/tb_linear_array_deque_top.sv =====
// Testbench for linear_array_deque_top: directed and random deque operations checked by a scoreboard.
`timescale 1ns / 100ps

import lad_pkg::*;

class deque_scoreboard;
  localparam int Depth = LadDepth;

  logic [DataW-1:0] slots [Depth];
  int               front_idx;
  int               rear_idx;
  lad_out_t         expected_q [$];
  int unsigned      mismatches;
  int unsigned      n_checked;

  function new();
    front_idx  = -1;
    rear_idx   = -1;
    mismatches = 0;
    n_checked  = 0;
    foreach (slots[i]) slots[i] = '0;
  endfunction

  function void add_result(logic [DataW-1:0] value, logic [1:0] status, logic last);
    lad_out_t r;
    r.value_out = value;
    r.status    = status;
    r.last      = last;
    expected_q.push_back(r);
  endfunction

  // Predict the results of one accepted item and update the deque state.
  function void note_input(lad_in_t it);
    case (it.func)
      FUNC_PUSH_REAR: begin
        if (rear_idx >= Depth - 1) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          rear_idx++;
          slots[rear_idx] = it.value_in;
          add_result('0, ST_OK, 1'b1);
        end
      end
      FUNC_POP_FRONT: begin
        if (front_idx == rear_idx) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          front_idx++;
          add_result(slots[front_idx], ST_OK, 1'b1);
        end
      end
      FUNC_PUSH_FRONT: begin
        if (front_idx < 0) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          slots[front_idx] = it.value_in;
          front_idx--;
          add_result('0, ST_OK, 1'b1);
        end
      end
      FUNC_POP_REAR: begin
        if (front_idx == rear_idx) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          add_result(slots[rear_idx], ST_OK, 1'b1);
          rear_idx--;
        end
      end
      FUNC_READ_ALL: begin
        if (front_idx == rear_idx) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = front_idx + 1; i <= rear_idx; i++) begin
            add_result(slots[i], ST_OK, i == rear_idx);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(lad_out_t got);
    lad_out_t want;
    n_checked++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected item: value %0d status %0d last %0d",
                 got.value_out, got.status, got.last);
      end
      return;
    end
    want = expected_q.pop_front();
    if (got.value_out !== want.value_out || got.status !== want.status ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected value %0d status %0d last %0d, got value %0d status %0d last %0d",
                 want.value_out, want.status, want.last,
                 got.value_out, got.status, got.last);
      end
    end
  endfunction
endclass

module tb_linear_array_deque_top;
  localparam int          Depth       = LadDepth;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandItems   = 250;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [2:0]  FUNC_SPARE_A = 3'd5;
  localparam logic [2:0]  FUNC_SPARE_B = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_C = 3'd7;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  lad_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_ready_i;
  lad_out_t out_item_o;

  deque_scoreboard sb = new();
  int unsigned     cycle_cnt;

  linear_array_deque_top #(
    .DEPTH(Depth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_op(input logic [2:0] func, input logic [DataW-1:0] value,
                         input bit may_idle);
    lad_in_t it;
    it.func     = func;
    it.value_in = value;
    while (may_idle && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(15))
      0:       return {1'b1, {(DataW-1){1'b0}}};
      1:       return {1'b0, {(DataW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_func();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return FUNC_PUSH_REAR;
    if (r < 45) return FUNC_POP_FRONT;
    if (r < 65) return FUNC_PUSH_FRONT;
    if (r < 85) return FUNC_POP_REAR;
    if (r < 95) return FUNC_READ_ALL;
    case ($urandom_range(2))
      0:       return FUNC_SPARE_A;
      1:       return FUNC_SPARE_B;
      default: return FUNC_SPARE_C;
    endcase
  endfunction

  // Result side: random stalls, one long hold-off, and a window with no stalls.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && sb.n_checked >= 150) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else if (sb.n_checked >= 60 && sb.n_checked < 110) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin
    int unsigned n_sent;
    logic [2:0]  f;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty and full corners
    send_op(FUNC_READ_ALL, rand_value(), 1'b1);
    send_op(FUNC_POP_FRONT, rand_value(), 1'b1);
    send_op(FUNC_POP_REAR, rand_value(), 1'b1);
    send_op(FUNC_PUSH_FRONT, rand_value(), 1'b1);
    send_op(FUNC_PUSH_REAR, {1'b1, {(DataW-1){1'b0}}}, 1'b1);
    send_op(FUNC_PUSH_REAR, {1'b0, {(DataW-1){1'b1}}}, 1'b1);
    send_op(FUNC_PUSH_REAR, '0, 1'b1);
    send_op(FUNC_PUSH_REAR, '1, 1'b1);
    repeat (Depth - 4) send_op(FUNC_PUSH_REAR, $urandom, 1'b1);
    send_op(FUNC_PUSH_REAR, $urandom, 1'b1);
    send_op(FUNC_READ_ALL, rand_value(), 1'b1);
    send_op(FUNC_POP_FRONT, rand_value(), 1'b1);
    send_op(FUNC_POP_FRONT, rand_value(), 1'b1);
    send_op(FUNC_PUSH_FRONT, 32'h5a5a_5a5a, 1'b1);
    send_op(FUNC_PUSH_FRONT, 32'ha5a5_a5a5, 1'b1);
    send_op(FUNC_PUSH_FRONT, $urandom, 1'b1);
    send_op(FUNC_POP_REAR, rand_value(), 1'b1);
    send_op(FUNC_SPARE_A, $urandom, 1'b1);
    send_op(FUNC_SPARE_B, $urandom, 1'b1);
    send_op(FUNC_SPARE_C, $urandom, 1'b1);
    send_op(FUNC_READ_ALL, rand_value(), 1'b1);
    send_op(FUNC_POP_REAR, rand_value(), 1'b1);

    n_sent = 0;
    while (n_sent < RandItems) begin
      f = rand_func();
      send_op(f, rand_value(), !(n_sent >= 60 && n_sent < 110));
      if (f <= FUNC_READ_ALL) n_sent++;
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
